// File: design/tset_pkg.sv
// ----------------------------------------------------------------------------
// tset_pkg
// Shared types and constants for the time sorted event table.
// ----------------------------------------------------------------------------
`default_nettype none

package tset_pkg;

    localparam int OPC_W     = 2;
    localparam int HOUR_W    = 5;
    localparam int MIN_W     = 6;
    localparam int TAG_W     = 16;
    localparam int POS_W     = 4;
    localparam int STAT_W    = 2;
    localparam int CNT_OUT_W = 5;

    typedef enum logic [OPC_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_READ   = 2'd2,
        OP_NOP    = 2'd3
    } opcode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_SHIFT,
        S_INS_PLACE,
        S_DEL_SHIFT,
        S_RD_WAIT,
        S_DONE
    } seq_state_t;

    // one stored table entry
    typedef struct packed {
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    // decoded request item
    typedef struct packed {
        opcode_t           opcode;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [TAG_W-1:0]  tag;
        logic [POS_W-1:0]  position;
    } cmd_t;

    // finished result item
    typedef struct packed {
        status_t              status;
        logic [CNT_OUT_W-1:0] entry_count;
        logic [HOUR_W-1:0]    hour;
        logic [MIN_W-1:0]     minute;
        logic [TAG_W-1:0]     tag;
    } rsp_t;

endpackage

`default_nettype wire

// File: design/tset_if.sv
// ----------------------------------------------------------------------------
// tset_if
// Valid/ready channels for request and response items.
// ----------------------------------------------------------------------------
`default_nettype none

interface tset_req_if
    import tset_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OPC_W-1:0]  opcode;
    logic [HOUR_W-1:0] new_hour;
    logic [MIN_W-1:0]  new_minute;
    logic [TAG_W-1:0]  new_tag;
    logic [POS_W-1:0]  position;

    modport source (
        output valid, opcode, new_hour, new_minute, new_tag, position,
        input  ready
    );
    modport sink (
        input  valid, opcode, new_hour, new_minute, new_tag, position,
        output ready
    );
endinterface

interface tset_rsp_if
    import tset_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [STAT_W-1:0]    status;
    logic [CNT_OUT_W-1:0] entry_count;
    logic [HOUR_W-1:0]    read_hour;
    logic [MIN_W-1:0]     read_minute;
    logic [TAG_W-1:0]     read_tag;

    modport source (
        output valid, status, entry_count, read_hour, read_minute, read_tag,
        input  ready
    );
    modport sink (
        input  valid, status, entry_count, read_hour, read_minute, read_tag,
        output ready
    );
endinterface

`default_nettype wire

// File: design/tset_ram.sv
// ----------------------------------------------------------------------------
// tset_ram
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tset_ram
    import tset_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire entry_t                   wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output entry_t                        rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: design/tset_seq.sv
// ----------------------------------------------------------------------------
// tset_seq
// Sequencer: one time compare and index adders, stepped over the table.
// ----------------------------------------------------------------------------
`default_nettype none

module tset_seq
    import tset_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire cmd_t                           cmd,
    output logic                                ready,
    output logic                                done,
    input  wire logic                           take,
    output rsp_t                                result,
    output logic                                wr_en,
    output logic [$clog2(TABLE_DEPTH)-1:0]      wr_addr,
    output entry_t                              wr_data,
    output logic                                rd_en,
    output logic [$clog2(TABLE_DEPTH)-1:0]      rd_addr,
    input  wire entry_t                         rd_data
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    seq_state_t       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    entry_t           new_reg, new_next;
    rsp_t             res_reg, res_next;

    logic [CMP_W-1:0] pos_w, cnt_w, idx_w;
    logic             full, pos_fits, pos_next_fits, del_more, later;

    assign pos_w         = CMP_W'(cmd.position);
    assign cnt_w         = CMP_W'(count_reg);
    assign idx_w         = CMP_W'(idx_reg);
    assign full          = (count_reg == CNT_W'(TABLE_DEPTH));
    assign pos_fits      = (pos_w < cnt_w);
    assign pos_next_fits = ((pos_w + CMP_W'(1)) < cnt_w);
    assign del_more      = ((idx_w + CMP_W'(2)) < cnt_w);

    // stored entry strictly later than the new time
    assign later = (rd_data.hour != new_reg.hour) ? (rd_data.hour > new_reg.hour)
                                                  : (rd_data.minute > new_reg.minute);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd.opcode)
                        OP_INSERT:
                        begin
                            if (full)
                                state_next = S_DONE;
                            else if (count_reg == '0)
                                state_next = S_INS_PLACE;
                            else
                                state_next = S_INS_SHIFT;
                        end
                        OP_DELETE:
                        begin
                            if (pos_fits && pos_next_fits)
                                state_next = S_DEL_SHIFT;
                            else
                                state_next = S_DONE;
                        end
                        OP_READ:  state_next = pos_fits ? S_RD_WAIT : S_DONE;
                        OP_NOP:   state_next = S_DONE;
                    endcase
                end
            end
            S_INS_SHIFT:
            begin
                if (!(later && idx_reg != CNT_W'(1)))
                    state_next = S_INS_PLACE;
            end
            S_INS_PLACE: state_next = S_DONE;
            S_DEL_SHIFT:
            begin
                if (!del_more)
                    state_next = S_DONE;
            end
            S_RD_WAIT:   state_next = S_DONE;
            S_DONE:
            begin
                if (take)
                    state_next = S_IDLE;
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // outputs: memory port and handshake
    always_comb
    begin
        ready   = 1'b0;
        done    = 1'b0;
        wr_en   = 1'b0;
        wr_addr = idx_reg[IDX_W-1:0];
        wr_data = rd_data;
        rd_en   = 1'b0;
        rd_addr = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                ready = 1'b1;
                if (start)
                begin
                    unique case (cmd.opcode)
                        OP_INSERT:
                        begin
                            rd_en   = !full && (count_reg != '0);
                            rd_addr = IDX_W'(cnt_w - CMP_W'(1));
                        end
                        OP_DELETE:
                        begin
                            rd_en   = pos_fits && pos_next_fits;
                            rd_addr = IDX_W'(pos_w + CMP_W'(1));
                        end
                        OP_READ:
                        begin
                            rd_en   = pos_fits;
                            rd_addr = IDX_W'(pos_w);
                        end
                        OP_NOP:
                        begin
                            rd_en = 1'b0;
                        end
                    endcase
                end
            end
            S_INS_SHIFT:
            begin
                if (later)
                begin
                    wr_en   = 1'b1;
                    rd_en   = (idx_reg != CNT_W'(1));
                    rd_addr = IDX_W'(idx_w - CMP_W'(2));
                end
            end
            S_INS_PLACE:
            begin
                wr_en   = 1'b1;
                wr_data = new_reg;
            end
            S_DEL_SHIFT:
            begin
                wr_en   = 1'b1;
                rd_en   = del_more;
                rd_addr = IDX_W'(idx_w + CMP_W'(2));
            end
            S_RD_WAIT: ;
            S_DONE:    done = 1'b1;
            default: ;
        endcase
    end

    // datapath
    always_comb
    begin
        count_next = count_reg;
        idx_next   = idx_reg;
        new_next   = new_reg;
        res_next   = res_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    new_next.hour   = cmd.hour;
                    new_next.minute = cmd.minute;
                    new_next.tag    = cmd.tag;
                    res_next        = '0;
                    res_next.status = ST_OK;
                    unique case (cmd.opcode)
                        OP_INSERT:
                        begin
                            idx_next = count_reg;
                            if (full)
                                res_next.status = ST_FULL;
                        end
                        OP_DELETE:
                        begin
                            idx_next = CNT_W'(cmd.position);
                            if (!pos_fits)
                                res_next.status = ST_NOT_FOUND;
                            else if (!pos_next_fits)
                                count_next = count_reg - CNT_W'(1);
                        end
                        OP_READ:
                        begin
                            if (!pos_fits)
                                res_next.status = ST_NOT_FOUND;
                        end
                        OP_NOP: ;
                    endcase
                end
            end
            S_INS_SHIFT:
            begin
                if (later)
                    idx_next = idx_reg - CNT_W'(1);
            end
            S_INS_PLACE: count_next = count_reg + CNT_W'(1);
            S_DEL_SHIFT:
            begin
                idx_next = idx_reg + CNT_W'(1);
                if (!del_more)
                    count_next = count_reg - CNT_W'(1);
            end
            S_RD_WAIT:
            begin
                res_next.hour   = rd_data.hour;
                res_next.minute = rd_data.minute;
                res_next.tag    = rd_data.tag;
            end
            S_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        new_reg <= new_next;
        res_reg <= res_next;
    end

    always_comb
    begin
        result             = res_reg;
        result.entry_count = CNT_OUT_W'(count_reg);
    end

endmodule

`default_nettype wire

// File: design/time_sorted_event_table.sv
// ----------------------------------------------------------------------------
// time_sorted_event_table
// Table of timed entries kept sorted by hour and minute; insert, delete, read.
// ----------------------------------------------------------------------------
//
//  channel  dir  payload                                          item
//  -------  ---  -----------------------------------------------  --------------
//  req      in   opcode, new_hour, new_minute, new_tag, position  one operation
//  rsp      out  status, entry_count, read_hour/minute/tag        one result
//
//  Insert moves each later entry up a slot, then writes the new one;
//  delete moves each entry past the position down a slot; read waits on
//  the registered read data; full, miss and the unused opcode go straight
//  to the result. Entries move through the table memory (one read, one
//  write port) and, on insert, the one time comparator. One item at a
//  time; req.ready is high only while the sequencer is idle. Results sit
//  in an output register, so the next item is taken while a result waits
//  on rsp.ready. Reset clears the state, count and output valid; no clear pass.
// ----------------------------------------------------------------------------
`default_nettype none

module time_sorted_event_table
    import tset_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    tset_req_if.sink   req,
    tset_rsp_if.source rsp
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam logic [CNT_OUT_W-1:0] FULL_CNT = CNT_OUT_W'(TABLE_DEPTH);

    cmd_t             cmd;
    rsp_t             seq_result;
    logic             seq_ready, seq_done, take;
    logic             wr_en, rd_en;
    logic [IDX_W-1:0] wr_addr, rd_addr;
    entry_t           wr_data, rd_data;

    // output register
    logic rsp_valid_reg, rsp_valid_next;
    rsp_t rsp_reg;

    assign cmd.opcode   = opcode_t'(req.opcode);
    assign cmd.hour     = req.new_hour;
    assign cmd.minute   = req.new_minute;
    assign cmd.tag      = req.new_tag;
    assign cmd.position = req.position;

    assign req.ready = seq_ready;

    // a finished result moves out once the output register is free
    assign take = seq_done && (!rsp_valid_reg || rsp.ready);

    tset_seq #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (req.valid && seq_ready),
        .cmd     (cmd),
        .ready   (seq_ready),
        .done    (seq_done),
        .take    (take),
        .result  (seq_result),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tset_ram #(
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (take)
            rsp_valid_next = 1'b1;
        else if (rsp.ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else
            rsp_valid_reg <= rsp_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            rsp_reg <= seq_result;
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_reg.status;
    assign rsp.entry_count = rsp_reg.entry_count;
    assign rsp.read_hour   = rsp_reg.hour;
    assign rsp.read_minute = rsp_reg.minute;
    assign rsp.read_tag    = rsp_reg.tag;

    // a full report always carries a full count
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == ST_FULL) |-> (rsp.entry_count == FULL_CNT))
        else $error("full status with count not at table depth");

    // only a successful read carries entry data
    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != ST_OK) |->
        (rsp.read_hour == '0 && rsp.read_minute == '0 && rsp.read_tag == '0))
        else $error("entry data on a failed operation");

    // sequencer never takes a new item while holding a result
    a_idle_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        seq_ready |-> !seq_done)
        else $error("sequencer ready while result pending");

    // a result handed over shows up on the output next cycle
    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> rsp_valid_reg)
        else $error("result lost on hand-over");

endmodule

`default_nettype wire

// File: sim/time_sorted_event_table_test.sv
// ----------------------------------------------------------------------------
// time_sorted_event_table_test
// Self-checking bench for the sorted event table: a queue-fed request driver,
// a response monitor and an item-level model of the table that predicts every
// result item. Covers the empty and full table, ties kept in arrival order,
// out-of-range times, misses past the count, the unused opcode and a long
// response stall that backs up the request side.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module time_sorted_event_table_test
    import tset_pkg::*;
();

    localparam int DEPTH       = 16;
    localparam int RAND_ITEMS  = 950;
    localparam int IDLE_PCT    = 30;    // chance of a gap or stall per cycle
    localparam int CALM_LO     = 400;   // no idling on either side in this
    localparam int CALM_HI     = 550;   //   window of accepted items
    localparam int HOLD_AT     = 700;   // results taken before the long hold
    localparam int HOLD_CYCLES = 150;
    localparam int DRAIN_WAIT  = 40;
    localparam int STUCK_LIMIT = 2000;  // cycles with no handshake at all

    logic clk = 1'b0;
    logic rst_n;

    tset_req_if req_ch ();
    tset_rsp_if rsp_ch ();

    time_sorted_event_table #(
        .TABLE_DEPTH (DEPTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    cmd_t pending_ops[$];       // items waiting to be offered
    rsp_t expected_results[$];  // predicted results, oldest first

    // shadow copy of the table, updated as items are accepted
    logic [HOUR_W-1:0] tbl_hour   [DEPTH];
    logic [MIN_W-1:0]  tbl_minute [DEPTH];
    logic [TAG_W-1:0]  tbl_tag    [DEPTH];
    int                tbl_count;

    int gen_count;   // count as the generator sees it, to aim positions
    int total_items;
    int req_taken;
    int rsp_taken;
    int error_count;
    int stuck_cycles;

    // coverage tallies for the closing summary
    int n_full, n_miss, n_read_ok, peak_count;

    // ------------------------------------------------------------------------
    // Mismatch reporting: one line each
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d (result %0d)",
                 $realtime, what, got, want, rsp_taken);
    endtask

    // ------------------------------------------------------------------------
    // Table model. Insert lands after every entry with an equal time, so
    // ties keep arrival order. Full table and positions at or past the count
    // leave everything untouched. Read fields are zero unless a read hits.
    // ------------------------------------------------------------------------
    function automatic rsp_t apply_table_op(input cmd_t c);
        rsp_t r;
        int   slot;
        int   k;
        r = '0;
        r.status = ST_OK;
        case (c.opcode)
            OP_INSERT: begin
                if (tbl_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    slot = 0;
                    while (slot < tbl_count &&
                           !(tbl_hour[slot] > c.hour ||
                             (tbl_hour[slot] == c.hour && tbl_minute[slot] > c.minute)))
                        slot++;
                    for (k = tbl_count; k > slot; k--) begin
                        tbl_hour[k]   = tbl_hour[k-1];
                        tbl_minute[k] = tbl_minute[k-1];
                        tbl_tag[k]    = tbl_tag[k-1];
                    end
                    tbl_hour[slot]   = c.hour;
                    tbl_minute[slot] = c.minute;
                    tbl_tag[slot]    = c.tag;
                    tbl_count++;
                end
            end
            OP_DELETE: begin
                if (c.position >= tbl_count) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    for (k = c.position; k + 1 < tbl_count; k++) begin
                        tbl_hour[k]   = tbl_hour[k+1];
                        tbl_minute[k] = tbl_minute[k+1];
                        tbl_tag[k]    = tbl_tag[k+1];
                    end
                    tbl_count--;
                end
            end
            OP_READ: begin
                if (c.position < tbl_count) begin
                    r.hour   = tbl_hour[c.position];
                    r.minute = tbl_minute[c.position];
                    r.tag    = tbl_tag[c.position];
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end
            default: ;  // unused opcode: no change, status ok
        endcase
        r.entry_count = tbl_count[CNT_OUT_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_op(input opcode_t op, input int h, input int m,
                            input int tg, input int pos);
        cmd_t c;
        c.opcode   = op;
        c.hour     = h[HOUR_W-1:0];
        c.minute   = m[MIN_W-1:0];
        c.tag      = tg[TAG_W-1:0];
        c.position = pos[POS_W-1:0];
        pending_ops.push_back(c);
        // track the count only to aim delete/read positions at live entries
        if (op == OP_INSERT && gen_count < DEPTH)
            gen_count++;
        else if (op == OP_DELETE && pos < gen_count)
            gen_count--;
    endtask

    // mostly legal times, a share drawn from a tiny set to force ties,
    // and a few over the full field width
    task automatic pick_time(output int h, output int m);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 25) begin
            h = 8 + $urandom_range(0, 1);
            m = $urandom_range(0, 1) * 15;
        end else if (roll < 35) begin
            h = $urandom_range(0, (1 << HOUR_W) - 1);
            m = $urandom_range(0, (1 << MIN_W) - 1);
        end else begin
            h = $urandom_range(0, 23);
            m = $urandom_range(0, 59);
        end
    endtask

    function automatic int pick_position();
        if (gen_count > 0 && $urandom_range(0, 99) < 65)
            return $urandom_range(0, gen_count - 1);
        return $urandom_range(0, DEPTH - 1);
    endfunction

    // Random part in bursts: fill-heavy bursts drive the table to full,
    // drain-heavy ones empty it, mixed ones wander in between.
    task automatic build_random_ops();
        int made;
        int mode;
        int burst;
        int roll;
        int ins_pct;
        int del_pct;
        int h;
        int m;
        made = 0;
        while (made < RAND_ITEMS) begin
            mode  = $urandom_range(0, 2);
            burst = $urandom_range(15, 45);
            case (mode)
                0:       begin ins_pct = 65; del_pct = 15; end
                1:       begin ins_pct = 15; del_pct = 60; end
                default: begin ins_pct = 35; del_pct = 30; end
            endcase
            repeat (burst) begin
                roll = $urandom_range(0, 99);
                pick_time(h, m);
                if (roll < 3)
                    queue_op(OP_NOP, h, m, $urandom, $urandom_range(0, DEPTH - 1));
                else if (roll < 3 + ins_pct)
                    queue_op(OP_INSERT, h, m, $urandom, $urandom_range(0, DEPTH - 1));
                else if (roll < 3 + ins_pct + del_pct)
                    queue_op(OP_DELETE, h, m, $urandom, pick_position());
                else
                    queue_op(OP_READ, h, m, $urandom, pick_position());
                made++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Request driver: offers the next queued item when the slot is free, random gaps aside.
    // Valid drops only when nothing is offered next, never pulsed.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin : drive_requests
        cmd_t nxt;
        if (!rst_n) begin
            req_ch.valid      <= 1'b0;
            req_ch.opcode     <= '0;
            req_ch.new_hour   <= '0;
            req_ch.new_minute <= '0;
            req_ch.new_tag    <= '0;
            req_ch.position   <= '0;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (pending_ops.size() != 0 &&
                ((req_taken >= CALM_LO && req_taken < CALM_HI) ||
                 $urandom_range(0, 99) >= IDLE_PCT)) begin
                nxt = pending_ops.pop_front();
                req_ch.valid      <= 1'b1;
                req_ch.opcode     <= nxt.opcode;
                req_ch.new_hour   <= nxt.hour;
                req_ch.new_minute <= nxt.minute;
                req_ch.new_tag    <= nxt.tag;
                req_ch.position   <= nxt.position;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Response sink: random stalls, a calm window, and one long hold so the
    // output register and the sequencer both fill and req.ready stays low.
    // ------------------------------------------------------------------------
    int  hold_left;
    logic hold_done;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
        end else if (hold_left != 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (!hold_done && rsp_taken >= HOLD_AT) begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            hold_done    <= 1'b1;
        end else begin
            rsp_ch.ready <= (rsp_taken >= CALM_LO && rsp_taken < CALM_HI) ||
                            ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predicts on every accepted request, checks every accepted
    // response against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : watch_channels
        cmd_t c;
        rsp_t want;
        if (rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                c.opcode   = opcode_t'(req_ch.opcode);
                c.hour     = req_ch.new_hour;
                c.minute   = req_ch.new_minute;
                c.tag      = req_ch.new_tag;
                c.position = req_ch.position;
                expected_results.push_back(apply_table_op(c));
                if (tbl_count > peak_count)
                    peak_count = tbl_count;
                req_taken <= req_taken + 1;
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, status", rsp_ch.status, -1);
                end else begin
                    want = expected_results.pop_front();
                    if (rsp_ch.status != want.status)
                        report_mismatch("status", rsp_ch.status, want.status);
                    if (rsp_ch.entry_count != want.entry_count)
                        report_mismatch("entry_count", rsp_ch.entry_count, want.entry_count);
                    if (rsp_ch.read_hour != want.hour)
                        report_mismatch("read_hour", rsp_ch.read_hour, want.hour);
                    if (rsp_ch.read_minute != want.minute)
                        report_mismatch("read_minute", rsp_ch.read_minute, want.minute);
                    if (rsp_ch.read_tag != want.tag)
                        report_mismatch("read_tag", rsp_ch.read_tag, want.tag);
                    case (want.status)
                        ST_FULL:      n_full++;
                        ST_NOT_FOUND: n_miss++;
                        default:      if (want.hour != 0 || want.minute != 0 ||
                                          want.tag != 0)
                                          n_read_ok++;
                    endcase
                end
                rsp_taken <= rsp_taken + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: no handshake on either channel for too long ends the run.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("[%0t] no handshake for %0d cycles, %0d results outstanding",
                     $realtime, STUCK_LIMIT, expected_results.size());
            $display("tb: failure");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        // drive every input to a known value from time zero
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.opcode     = '0;
        req_ch.new_hour   = '0;
        req_ch.new_minute = '0;
        req_ch.new_tag    = '0;
        req_ch.position   = '0;
        rsp_ch.ready      = 1'b0;

        foreach (tbl_hour[i]) begin
            tbl_hour[i]   = '0;
            tbl_minute[i] = '0;
            tbl_tag[i]    = '0;
        end
        tbl_count    = 0;
        gen_count    = 0;
        req_taken    = 0;
        rsp_taken    = 0;
        error_count  = 0;
        stuck_cycles = 0;
        n_full       = 0;
        n_miss       = 0;
        n_read_ok    = 0;
        peak_count   = 0;

        // Directed part.
        // Empty table: read and delete both miss; unused opcode with all
        // fields at their top value changes nothing.
        queue_op(OP_READ,   0, 0, 0, 0);
        queue_op(OP_DELETE, 0, 0, 0, DEPTH - 1);
        queue_op(OP_NOP,    31, 63, 16'hFFFF, DEPTH - 1);
        // out-of-range time sorts by plain value, so it ends up last
        queue_op(OP_INSERT, 31, 63, 16'hFFFF, 0);
        queue_op(OP_INSERT, 0, 0, 0, 0);
        // equal times keep arrival order
        queue_op(OP_INSERT, 12, 30, 1, 0);
        queue_op(OP_INSERT, 12, 30, 2, 0);
        // fill to the top, one more tie and the latest legal time among them
        queue_op(OP_INSERT, 12, 30, 3, 0);
        queue_op(OP_INSERT, 23, 59, 16'hA5A5, 0);
        for (int i = 0; i < DEPTH - 6; i++)
            queue_op(OP_INSERT, $urandom_range(0, 23), $urandom_range(0, 59),
                     $urandom, 0);
        // full table: insert is refused
        queue_op(OP_INSERT, 1, 1, 16'h5A5A, 0);
        queue_op(OP_READ,   0, 0, 0, DEPTH - 1);
        queue_op(OP_READ,   0, 0, 0, 0);
        // remove the last then the first entry, then miss just past the end
        queue_op(OP_DELETE, 0, 0, 0, DEPTH - 1);
        queue_op(OP_DELETE, 0, 0, 0, 0);
        queue_op(OP_DELETE, 0, 0, 0, DEPTH - 2);

        build_random_ops();
        total_items = pending_ops.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        wait (req_taken == total_items && expected_results.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (expected_results.size() != 0)
            report_mismatch("results never delivered", 0, expected_results.size());

        $display("run: %0d items, %0d full refusals, %0d misses, %0d hit reads",
                 total_items, n_full, n_miss, n_read_ok);
        $display("run: table peaked at %0d entries, %0d mismatches, one %0d-cycle hold",
                 peak_count, error_count, HOLD_CYCLES);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
